// File: rtl/core/rafr_pkg.sv
`timescale 1ns / 1ps

package rafr_pkg;

  localparam logic [7:0]  StartByte      = 8'h7E;
  localparam logic [15:0] LengthExpected = 16'h0006;
  localparam logic [7:0]  ApiIdExpected  = 8'h01;
  localparam logic [7:0]  FrameIdExpected = 8'h00;
  localparam logic [7:0]  OptionsExpected = 8'h01;
  localparam logic [7:0]  SumExpected    = 8'hFF;

  // frame byte positions
  localparam logic [3:0] PosLenHi   = 4'd1;
  localparam logic [3:0] PosLenLo   = 4'd2;
  localparam logic [3:0] PosApiId   = 4'd3;
  localparam logic [3:0] PosFrameId = 4'd4;
  localparam logic [3:0] PosAddrHi  = 4'd5;
  localparam logic [3:0] PosAddrLo  = 4'd6;
  localparam logic [3:0] PosOptions = 4'd7;
  localparam logic [3:0] PosCharge  = 4'd8;
  localparam logic [3:0] PosCsum    = 4'd9;

  typedef enum logic [3:0] {
    PH_WAIT   = 4'b0001,
    PH_LEN_HI = 4'b0010,
    PH_LEN_LO = 4'b0100,
    PH_DATA   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        vld;
    logic [15:0] addr;
    logic [7:0]  charge;
  } result_t;

endpackage

// File: rtl/core/rafr_parser.sv
`timescale 1ns / 1ps

module rafr_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  input  logic              space,
  output rafr_pkg::result_t res
);

  logic                byte_vld;
  logic [7:0]          byte_q;
  logic                fire;

  rafr_pkg::phase_t    phase, phase_next;
  logic [3:0]          byte_position, byte_position_next;
  logic [7:0]          length_high_byte, length_high_byte_next;
  logic [7:0]          running_sum, running_sum_next;
  logic                header_ok, header_ok_next;
  logic [15:0]         captured_address, captured_address_next;
  logic [7:0]          captured_charge, captured_charge_next;
  logic                emit;

  assign fire     = byte_vld && space;
  assign in_ready = !byte_vld || space;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (in_ready) begin
      byte_vld <= in_valid;
    end
    if (in_ready && in_valid) begin
      byte_q <= rx_byte;
    end
  end

  always_comb begin
    phase_next            = phase;
    byte_position_next    = byte_position;
    length_high_byte_next = length_high_byte;
    running_sum_next      = running_sum;
    header_ok_next        = header_ok;
    captured_address_next = captured_address;
    captured_charge_next  = captured_charge;
    emit                  = 1'b0;
    case (phase)
      rafr_pkg::PH_WAIT: begin
        if (byte_q == rafr_pkg::StartByte) begin
          phase_next         = rafr_pkg::PH_LEN_HI;
          byte_position_next = rafr_pkg::PosLenHi;
        end
      end
      rafr_pkg::PH_LEN_HI: begin
        length_high_byte_next = byte_q;
        phase_next            = rafr_pkg::PH_LEN_LO;
        byte_position_next    = rafr_pkg::PosLenLo;
      end
      rafr_pkg::PH_LEN_LO: begin
        if ({length_high_byte, byte_q} == rafr_pkg::LengthExpected) begin
          phase_next         = rafr_pkg::PH_DATA;
          byte_position_next = rafr_pkg::PosApiId;
          running_sum_next   = 8'h00;
          header_ok_next     = 1'b1;
        end else begin
          // bad length: the failing byte is not rechecked as a start byte
          phase_next            = rafr_pkg::PH_WAIT;
          byte_position_next    = 4'd0;
          length_high_byte_next = 8'h00;
          running_sum_next      = 8'h00;
          header_ok_next        = 1'b1;
        end
      end
      rafr_pkg::PH_DATA: begin
        running_sum_next   = running_sum + byte_q;
        byte_position_next = byte_position + 4'd1;
        case (byte_position)
          rafr_pkg::PosApiId:   if (byte_q != rafr_pkg::ApiIdExpected) header_ok_next = 1'b0;
          rafr_pkg::PosFrameId: if (byte_q != rafr_pkg::FrameIdExpected) header_ok_next = 1'b0;
          rafr_pkg::PosAddrHi:  captured_address_next[15:8] = byte_q;
          rafr_pkg::PosAddrLo:  captured_address_next[7:0] = byte_q;
          rafr_pkg::PosOptions: if (byte_q != rafr_pkg::OptionsExpected) header_ok_next = 1'b0;
          rafr_pkg::PosCharge:  captured_charge_next = byte_q;
          default: ;
        endcase
        if (byte_position == rafr_pkg::PosCsum) begin
          emit                  = header_ok_next && (running_sum_next == rafr_pkg::SumExpected);
          phase_next            = rafr_pkg::PH_WAIT;
          byte_position_next    = 4'd0;
          length_high_byte_next = 8'h00;
          running_sum_next      = 8'h00;
          header_ok_next        = 1'b1;
        end
      end
      default: begin
        phase_next            = rafr_pkg::PH_WAIT;
        byte_position_next    = 4'd0;
        length_high_byte_next = 8'h00;
        running_sum_next      = 8'h00;
        header_ok_next        = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= rafr_pkg::PH_WAIT;
      byte_position    <= 4'd0;
      length_high_byte <= 8'h00;
      running_sum      <= 8'h00;
      header_ok        <= 1'b1;
      captured_address <= 16'h0000;
      captured_charge  <= 8'h00;
    end else if (fire) begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      length_high_byte <= length_high_byte_next;
      running_sum      <= running_sum_next;
      header_ok        <= header_ok_next;
      captured_address <= captured_address_next;
      captured_charge  <= captured_charge_next;
    end
  end

  assign res.vld    = fire && emit;
  assign res.addr   = captured_address;
  assign res.charge = captured_charge;

  a_data_pos: assert property (@(posedge clk) disable iff (rst)
    (phase == rafr_pkg::PH_DATA) |-> (byte_position >= rafr_pkg::PosApiId &&
                                      byte_position <= rafr_pkg::PosCsum))
    else $error("data phase with position out of frame");

  a_res_fire: assert property (@(posedge clk) disable iff (rst)
    res.vld |-> (phase == rafr_pkg::PH_DATA && byte_position == rafr_pkg::PosCsum))
    else $error("result outside checksum byte");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (byte_vld && !space) |=> (byte_vld && $stable(byte_q) && $stable(phase)))
    else $error("stalled item lost");

endmodule

// File: rtl/core/rafr_out_fifo.sv
`timescale 1ns / 1ps

module rafr_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  rafr_pkg::result_t res,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       peer_address,
  output logic [7:0]        charge_level
);

  logic [23:0] mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign space     = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = res.vld;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      mem[wr_ptr] <= {res.addr, res.charge};
    end
  end

  assign peer_address = mem[rd_ptr][23:8];
  assign charge_level = mem[rd_ptr][7:0];

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("fifo count overflow");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> (space || pop))
    else $error("push into full fifo");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("fifo pointers disagree with count");

endmodule

// File: rtl/core/radio_api_frame_receiver_unit.sv
`timescale 1ns / 1ps

// Radio API frame receiver.
// Input channel: one received serial byte per item on rx_byte, in_valid/in_ready.
// Output channel: one item per good frame (peer_address, charge_level),
// out_valid/out_ready. Bad length, bad header or bad checksum frames give no item.
// A frame is 0x7E, length 0x0006, then seven bytes: API id, frame id,
// address high/low, options, charge, checksum. 0x7E inside the body is data.
// out_valid rises once a frame's last byte has passed the input register and the
// parse step has written the result into the 2-entry output queue.
// Throughput: one byte per cycle unless the output queue is full; the parse step is
// a single state update per byte between the input register and the output queue.
// If the receiver stalls, the queue holds up to two results; in_ready drops only
// once the queue is full and a byte is waiting in the input register.
// Reset (rst, synchronous) empties the input register and the output queue and
// returns the parser to waiting for a start byte.
module radio_api_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] peer_address,
  output logic [7:0]  charge_level
);

  rafr_pkg::result_t res;
  logic              space;

  rafr_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .space    (space),
    .res      (res)
  );

  rafr_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .space        (space),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .peer_address (peer_address),
    .charge_level (charge_level)
  );

endmodule

// File: test/radio_api_frame_receiver_unit_tb.sv
`timescale 1ns / 1ps

module radio_api_frame_receiver_unit_tb;
  import rafr_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomBytes = 1100;
  localparam int unsigned DrainCycles = 8;
  localparam logic [3:0]  FrameBytes  = 4'd10;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  charge;
  } beacon_t;

  typedef enum int {
    FR_GOOD,
    FR_BAD_LEN_HI,
    FR_BAD_LEN_LO,
    FR_BAD_API,
    FR_BAD_FID,
    FR_BAD_OPT,
    FR_BAD_SUM,
    FR_NO_START
  } frame_flaw_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] peer_address;
  logic [7:0]  charge_level;

  logic        idle_en;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  // shadow of the parser
  phase_t      trk_phase;
  logic [3:0]  trk_pos;
  logic [7:0]  trk_len_hi;
  logic [7:0]  trk_sum;
  logic        trk_hdr_ok;
  logic [15:0] trk_addr;
  logic [7:0]  trk_charge;

  beacon_t     pending_beacons[$];

  radio_api_frame_receiver_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .peer_address (peer_address),
    .charge_level (charge_level)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_beacons.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= idle_en ? ($urandom_range(0, 99) >= 30) : 1'b1;
  end

  always @(posedge clk) begin : check_results
    beacon_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_beacons.size() == 0) begin
        $display("%0t: unexpected result, expected none, got addr=%h charge=%h",
                 $time, peer_address, charge_level);
        err_count++;
      end else begin
        want = pending_beacons.pop_front();
        if (peer_address !== want.addr) begin
          $display("%0t: peer_address expected %h actual %h", $time, want.addr, peer_address);
          err_count++;
        end
        if (charge_level !== want.charge) begin
          $display("%0t: charge_level expected %h actual %h",
                   $time, want.charge, charge_level);
          err_count++;
        end
      end
    end
  end

  function automatic void tracker_idle();
    trk_phase  = PH_WAIT;
    trk_pos    = '0;
    trk_len_hi = '0;
    trk_sum    = '0;
    trk_hdr_ok = 1'b1;
  endfunction

  function automatic void track_rx_byte(input logic [7:0] b);
    case (trk_phase)
      PH_WAIT: begin
        if (b == StartByte) begin
          trk_phase = PH_LEN_HI;
          trk_pos   = PosLenHi;
        end
      end
      PH_LEN_HI: begin
        trk_len_hi = b;
        trk_phase  = PH_LEN_LO;
        trk_pos    = PosLenLo;
      end
      PH_LEN_LO: begin
        if ({trk_len_hi, b} == LengthExpected) begin
          trk_phase  = PH_DATA;
          trk_pos    = PosApiId;
          trk_sum    = '0;
          trk_hdr_ok = 1'b1;
        end else begin
          tracker_idle();
        end
      end
      default: begin
        trk_sum = trk_sum + b;
        case (trk_pos)
          PosApiId:   if (b != ApiIdExpected) trk_hdr_ok = 1'b0;
          PosFrameId: if (b != FrameIdExpected) trk_hdr_ok = 1'b0;
          PosAddrHi:  trk_addr[15:8] = b;
          PosAddrLo:  trk_addr[7:0] = b;
          PosOptions: if (b != OptionsExpected) trk_hdr_ok = 1'b0;
          PosCharge:  trk_charge = b;
          default: ;
        endcase
        trk_pos = trk_pos + 4'd1;
        if (trk_pos >= FrameBytes || trk_pos < PosApiId) begin
          if (trk_hdr_ok && trk_sum == SumExpected)
            pending_beacons.push_back({trk_addr, trk_charge});
          tracker_idle();
        end
      end
    endcase
  endfunction

  function automatic logic [7:0] other_than(input logic [7:0] v);
    return v ^ 8'($urandom_range(1, 255));
  endfunction

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    track_rx_byte(b);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [15:0] addr, input logic [7:0] charge,
                            input frame_flaw_t flaw);
    logic [7:0] fb[10];
    logic [7:0] acc;
    fb[0] = StartByte;
    fb[1] = LengthExpected[15:8];
    fb[2] = LengthExpected[7:0];
    fb[3] = ApiIdExpected;
    fb[4] = FrameIdExpected;
    fb[5] = addr[15:8];
    fb[6] = addr[7:0];
    fb[7] = OptionsExpected;
    fb[8] = charge;
    case (flaw)
      FR_BAD_LEN_HI: fb[1] = other_than(fb[1]);
      FR_BAD_LEN_LO: fb[2] = other_than(fb[2]);
      FR_BAD_API:    fb[3] = other_than(fb[3]);
      FR_BAD_FID:    fb[4] = other_than(fb[4]);
      FR_BAD_OPT:    fb[7] = other_than(fb[7]);
      default: ;
    endcase
    acc = '0;
    for (int i = PosApiId; i < PosCsum; i++) acc = acc + fb[i];
    fb[9] = SumExpected - acc;
    if (flaw == FR_BAD_SUM) fb[9] = other_than(fb[9]);
    for (int i = (flaw == FR_NO_START) ? 1 : 0; i < 10; i++) send_byte(fb[i]);
  endtask

  task automatic test_clean_frames();
    send_frame(16'h0000, 8'h00, FR_GOOD);
    send_frame(16'hFFFF, 8'hFF, FR_GOOD);
  endtask

  task automatic test_length_reject();
    send_frame(16'($urandom), 8'($urandom), FR_BAD_LEN_HI);
    send_frame(16'($urandom), 8'($urandom), FR_BAD_LEN_LO);
    // low length byte equal to the start byte must not open a new frame
    send_byte(StartByte);
    send_byte(LengthExpected[15:8]);
    send_byte(StartByte);
    send_frame(16'h1234, 8'h56, FR_NO_START);
  endtask

  task automatic test_start_in_body();
    send_frame(16'h7E7E, 8'h7E, FR_GOOD);
    // cut-off frame: the next start byte lands in its body as data
    send_byte(StartByte);
    send_byte(LengthExpected[15:8]);
    send_byte(LengthExpected[7:0]);
    send_byte(ApiIdExpected);
    send_frame(16'hA55A, 8'h3C, FR_GOOD);
    send_frame(16'h0102, 8'h03, FR_GOOD);
  endtask

  task automatic test_header_reject();
    send_frame(16'($urandom), 8'($urandom), FR_BAD_API);
    send_frame(16'($urandom), 8'($urandom), FR_BAD_FID);
    send_frame(16'($urandom), 8'($urandom), FR_BAD_OPT);
    send_frame(16'h8001, 8'h80, FR_GOOD);
  endtask

  task automatic test_checksum_reject();
    send_frame(16'($urandom), 8'($urandom), FR_BAD_SUM);
    send_frame(16'h4321, 8'h64, FR_GOOD);
  endtask

  task automatic test_random_traffic();
    int unsigned frame_bytes;
    int unsigned pick;
    frame_flaw_t flaw;
    frame_bytes = 0;
    while (frame_bytes < RandomBytes) begin
      // a stretch in the middle runs with no idling on either side
      idle_en = !(frame_bytes >= RandomBytes / 3 && frame_bytes < RandomBytes / 2);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        flaw = (pick < 70) ? FR_GOOD
                           : frame_flaw_t'($urandom_range(FR_BAD_LEN_HI, FR_NO_START));
        send_frame(16'($urandom), 8'($urandom), flaw);
        frame_bytes += 10;
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    rx_byte   = '0;
    out_ready = 1'b0;
    idle_en   = 1'b1;
    tracker_idle();
    trk_addr   = '0;
    trk_charge = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_clean_frames();
    test_length_reject();
    test_start_in_body();
    test_header_reject();
    test_checksum_reject();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pending_beacons.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
